// ===== sv/sfd_pkg.sv =====
`default_nettype none

package sfd_pkg;

    // Frame syntax characters
    localparam logic [7:0] CH_OPEN  = 8'h3C;  // '<'
    localparam logic [7:0] CH_CLOSE = 8'h3E;  // '>'
    localparam logic [7:0] CH_TAG   = 8'h23;  // '#'
    localparam logic [7:0] CH_CPU   = 8'h43;  // 'C'
    localparam logic [7:0] CH_IP    = 8'h49;  // 'I'

    // Commands from controller to datapath
    typedef struct packed {
        logic store;       // take the accepted byte into the frame store
        logic decide;      // latch the frame check result
        logic scan_step;   // advance the tag scan by one byte
        logic rd_cpu;      // read the CPU field byte
        logic cap_cpu;     // capture the CPU field byte
        logic rd_cnt;      // read the IP count byte
        logic cap_cnt;     // capture the IP count byte
        logic eval;        // validate the IP field and load the address pointer
        logic addr_rd;     // read the next address byte
        logic addr_shift;  // shift the returned address byte in
        logic next_addr;   // move on to the next address
        logic clear;       // drop the frame and start afresh
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic rx_close;    // incoming byte closes the frame
        logic frame_good;  // no overflow, start marker and length byte agree
        logic scan_last;   // this scan step handles the final stored byte
        logic ip_go;       // IP field valid with at least one address
        logic last;        // result on show is the final one of the frame
    } t_sts;

endpackage

`default_nettype wire

// ===== sv/sfd_ctrl.sv =====
`default_nettype none

module sfd_ctrl
    import sfd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECIDE  = 4'd1;
    localparam logic [3:0] S_SCAN    = 4'd2;
    localparam logic [3:0] S_CPU_RD  = 4'd3;
    localparam logic [3:0] S_CNT_RD  = 4'd4;
    localparam logic [3:0] S_CNT_CAP = 4'd5;
    localparam logic [3:0] S_EVAL    = 4'd6;
    localparam logic [3:0] S_ADDR    = 4'd7;
    localparam logic [3:0] S_EMIT    = 4'd8;

    localparam logic [2:0] ADDR_BYTES = 3'd4;

    logic [3:0] r_state, n_state;
    logic [2:0] r_t, n_t;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_EMIT);

    // Sequence the frame: collect, check, scan, fetch fields, emit
    always_comb begin
        n_state = r_state;
        n_t     = r_t;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.store = 1'b1;
                    if (i_sts.rx_close) begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = i_sts.frame_good ? S_SCAN : S_EMIT;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_CPU_RD;
                end
            end
            S_CPU_RD: begin
                o_cmd.rd_cpu = 1'b1;
                n_state = S_CNT_RD;
            end
            S_CNT_RD: begin
                o_cmd.cap_cpu = 1'b1;
                o_cmd.rd_cnt  = 1'b1;
                n_state = S_CNT_CAP;
            end
            S_CNT_CAP: begin
                o_cmd.cap_cnt = 1'b1;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_t = '0;
                n_state = i_sts.ip_go ? S_ADDR : S_EMIT;
            end
            S_ADDR: begin
                // Issue four reads back to back, shift each one in the cycle after its read
                o_cmd.addr_rd    = (r_t < ADDR_BYTES);
                o_cmd.addr_shift = (r_t != 3'd0);
                if (r_t == ADDR_BYTES) begin
                    n_t = '0;
                    n_state = S_EMIT;
                end else begin
                    n_t = r_t + 3'd1;
                end
            end
            S_EMIT: begin
                if (i_ready) begin
                    if (i_sts.last) begin
                        o_cmd.clear = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.next_addr = 1'b1;
                        n_state = S_ADDR;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_t     <= '0;
        end else begin
            r_state <= n_state;
            r_t     <= n_t;
        end
    end

    a_hs_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("input and output handshakes open together");

    a_close_to_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_sts.rx_close) |=> (r_state == S_DECIDE))
        else $error("closing byte did not start the frame check");

    a_last_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && i_sts.last) |=> o_ready)
        else $error("input not reopened after the final result");

endmodule

`default_nettype wire

// ===== sv/sfd_dpath.sv =====
`default_nettype none

module sfd_dpath
    import sfd_pkg::*;
#(
    parameter int BUFFER_DEPTH  = 64,
    parameter int MAX_ADDRESSES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [7:0]  i_rx_byte,
    output logic        o_frame_ok,
    output logic        o_overflow,
    output logic        o_cpu_valid,
    output logic [7:0]  o_cpu_load,
    output logic        o_ip_valid,
    output logic [7:0]  o_ip_count,
    output logic [3:0]  o_address_index,
    output logic [31:0] o_ip_address,
    output logic        o_last
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int PW = $clog2(BUFFER_DEPTH + 2);
    localparam int KW = (MAX_ADDRESSES > 1) ? $clog2(MAX_ADDRESSES) : 1;

    // Frame store
    logic [7:0] r_mem [BUFFER_DEPTH];
    logic [7:0] r_rd_data;

    // Collection state
    logic [CW-1:0] r_fill;
    logic          r_ovf;
    logic [7:0]    r_b0, r_b1;
    logic          r_frame_ok;

    // Scan state
    logic [PW-1:0] r_pos;
    logic [7:0]    r_prev;
    logic          r_c_open, r_c_hs, r_c_he;
    logic [CW-1:0] r_c_first;
    logic [AW-1:0] r_c_final;
    logic          r_i_open, r_i_hs, r_i_he;
    logic [CW-1:0] r_i_first;
    logic [AW-1:0] r_i_final;

    // Field results
    logic          r_cpu_ok;
    logic [7:0]    r_cpu;
    logic [7:0]    r_cnt;
    logic          r_ip_ok;
    logic          r_multi;
    logic [AW-1:0] r_ptr;
    logic [31:0]   r_addr;
    logic [KW-1:0] r_k;

    logic          full;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          step_act, nxt_ok;
    logic          c_start, c_end, i_start, i_end;
    logic          c_found, i_found;
    logic [9:0]    i_span;
    logic          ip_ok_c;
    logic [7:0]    k8;

    assign full = (r_fill == CW'(BUFFER_DEPTH));

    // Store accepted bytes while room remains
    always_ff @(posedge i_clk) begin
        if (i_cmd.store && !full) begin
            r_mem[r_fill[AW-1:0]] <= i_rx_byte;
        end
    end

    // Select the single read address
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (i_cmd.scan_step && (r_pos < PW'(r_fill))) begin
            rd_en   = 1'b1;
            rd_addr = r_pos[AW-1:0];
        end else if (i_cmd.rd_cpu && c_found) begin
            rd_en   = 1'b1;
            rd_addr = r_c_first[AW-1:0];
        end else if (i_cmd.rd_cnt && i_found) begin
            rd_en   = 1'b1;
            rd_addr = r_i_first[AW-1:0];
        end else if (i_cmd.addr_rd) begin
            rd_en   = 1'b1;
            rd_addr = r_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Scan step: r_prev holds byte r_pos-2, read data holds byte r_pos-1
    assign step_act = i_cmd.scan_step && (r_pos >= PW'(2));
    assign nxt_ok   = (r_pos <= PW'(r_fill));
    assign c_start  = (r_prev == CH_TAG) && nxt_ok && (r_rd_data == CH_CPU);
    assign i_start  = (r_prev == CH_TAG) && nxt_ok && (r_rd_data == CH_IP);
    assign c_end    = r_c_open && ((r_prev == CH_TAG) || (r_prev == CH_CLOSE));
    assign i_end    = r_i_open && ((r_prev == CH_TAG) || (r_prev == CH_CLOSE));

    // Field checks
    assign c_found = r_c_hs && r_c_he && (CW'(r_c_final) == r_c_first);
    assign i_found = r_i_hs && r_i_he && (CW'(r_i_final) >= r_i_first);
    assign i_span  = 10'(r_i_final) - 10'(r_i_first);
    assign ip_ok_c = i_found && (i_span == {r_cnt, 2'b00})
                     && (r_cnt <= 8'(MAX_ADDRESSES));

    assign k8 = 8'(r_k);

    always_comb begin
        o_sts            = '0;
        o_sts.rx_close   = (i_rx_byte == CH_CLOSE);
        o_sts.frame_good = !r_ovf && (r_fill >= CW'(2)) && (r_b0 == CH_OPEN)
                           && (r_b1 == 8'(r_fill));
        o_sts.scan_last  = (r_pos == (PW'(r_fill) + PW'(1)));
        o_sts.ip_go      = ip_ok_c && (r_cnt != 8'd0);
        o_sts.last       = !r_multi || (k8 == (r_cnt - 8'd1));
    end

    // Frame control and field registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_fill     <= '0;
            r_ovf      <= 1'b0;
            r_frame_ok <= 1'b0;
            r_pos      <= '0;
            r_c_open   <= 1'b0;
            r_c_hs     <= 1'b0;
            r_c_he     <= 1'b0;
            r_i_open   <= 1'b0;
            r_i_hs     <= 1'b0;
            r_i_he     <= 1'b0;
            r_cpu_ok   <= 1'b0;
            r_cpu      <= '0;
            r_cnt      <= '0;
            r_ip_ok    <= 1'b0;
            r_multi    <= 1'b0;
            r_addr     <= '0;
            r_k        <= '0;
        end else begin
            // Collect: count stored bytes, flag overflow on a byte that arrives when full
            if (i_cmd.store) begin
                if (full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_fill <= r_fill + CW'(1);
                end
            end
            if (i_cmd.decide) begin
                r_frame_ok <= o_sts.frame_good;
            end
            // Scan: track the last opening tag of each kind and its end
            if (i_cmd.scan_step) begin
                r_pos <= r_pos + PW'(1);
            end
            if (step_act) begin
                if (c_start) begin
                    r_c_first <= CW'(r_pos);
                    r_c_hs    <= 1'b1;
                    r_c_he    <= 1'b0;
                    r_c_open  <= 1'b1;
                end else if (c_end) begin
                    r_c_final <= AW'(r_pos - PW'(3));
                    r_c_he    <= 1'b1;
                    r_c_open  <= 1'b0;
                end
                if (i_start) begin
                    r_i_first <= CW'(r_pos);
                    r_i_hs    <= 1'b1;
                    r_i_he    <= 1'b0;
                    r_i_open  <= 1'b1;
                end else if (i_end) begin
                    r_i_final <= AW'(r_pos - PW'(3));
                    r_i_he    <= 1'b1;
                    r_i_open  <= 1'b0;
                end
            end
            // Fields: capture and validate
            if (i_cmd.cap_cpu) begin
                r_cpu_ok <= c_found;
                r_cpu    <= c_found ? r_rd_data : 8'd0;
            end
            if (i_cmd.cap_cnt) begin
                r_cnt <= i_found ? r_rd_data : 8'd0;
            end
            if (i_cmd.eval) begin
                r_ip_ok <= ip_ok_c;
                r_multi <= ip_ok_c && (r_cnt != 8'd0);
            end
            // Addresses: assemble most significant byte first
            if (i_cmd.addr_shift) begin
                r_addr <= {r_addr[23:0], r_rd_data};
            end
            if (i_cmd.next_addr) begin
                r_k <= r_k + KW'(1);
            end
        end
    end

    // Payload registers without reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.store && (r_fill == CW'(0))) begin
            r_b0 <= i_rx_byte;
        end
        if (i_cmd.store && (r_fill == CW'(1))) begin
            r_b1 <= i_rx_byte;
        end
        if (i_cmd.scan_step && (r_pos != PW'(0))) begin
            r_prev <= r_rd_data;
        end
        if (i_cmd.eval) begin
            r_ptr <= r_i_first[AW-1:0] + AW'(1);
        end else if (i_cmd.addr_rd) begin
            r_ptr <= r_ptr + AW'(1);
        end
    end

    assign o_frame_ok      = r_frame_ok;
    assign o_overflow      = r_ovf;
    assign o_cpu_valid     = r_cpu_ok;
    assign o_cpu_load      = r_cpu;
    assign o_ip_valid      = r_ip_ok;
    assign o_ip_count      = r_cnt;
    assign o_address_index = k8[3:0];
    assign o_ip_address    = r_addr;
    assign o_last          = o_sts.last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(BUFFER_DEPTH))
        else $error("fill count beyond store depth");

    a_ovf_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> full)
        else $error("overflow flagged while store has room");

    a_multi_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_multi |-> (r_frame_ok && r_ip_ok && !r_ovf))
        else $error("address results without a valid frame and IP field");

endmodule

`default_nettype wire

// ===== sv/status_frame_deframer_top.sv =====
// Status frame deframer.
// Input channel (i_valid/o_ready, i_rx_byte): one received byte per request.
// While a frame is being collected a byte is taken every cycle. A '>' byte
// closes the frame; the block then stops taking bytes until the frame's last
// result has been taken.
// Output channel (o_valid/i_ready): one result per frame, or one per address
// of a valid IP field, with o_last on the final one.
// After the closing byte comes a check state; for a well-formed frame the
// block then scans the frame through the single read port of the frame
// store, fetches the CPU and count bytes, and does four byte reads per
// address before each address result shows. Overflowed or malformed frames
// show their result straight after the check state. Throughput is bound by
// that single store read port.
// Reset (synchronous, active low) empties the store and clears all flags;
// no clearing pass is needed. A stalled receiver holds the result on show
// and the block waits; no byte is taken until the frame is delivered.
`default_nettype none

module status_frame_deframer_top
    import sfd_pkg::*;
#(
    parameter int BUFFER_DEPTH  = 64,
    parameter int MAX_ADDRESSES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_frame_ok,
    output logic        o_overflow,
    output logic        o_cpu_valid,
    output logic [7:0]  o_cpu_load,
    output logic        o_ip_valid,
    output logic [7:0]  o_ip_count,
    output logic [3:0]  o_address_index,
    output logic [31:0] o_ip_address,
    output logic        o_last
);

    t_cmd cmd;
    t_sts sts;

    sfd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    sfd_dpath #(
        .BUFFER_DEPTH  (BUFFER_DEPTH),
        .MAX_ADDRESSES (MAX_ADDRESSES)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_rx_byte       (i_rx_byte),
        .o_frame_ok      (o_frame_ok),
        .o_overflow      (o_overflow),
        .o_cpu_valid     (o_cpu_valid),
        .o_cpu_load      (o_cpu_load),
        .o_ip_valid      (o_ip_valid),
        .o_ip_count      (o_ip_count),
        .o_address_index (o_address_index),
        .o_ip_address    (o_ip_address),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none

module tb_top
    import sfd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_DEPTH = 64;
    localparam int ADDR_LIMIT  = 16;

    // One result item as it leaves the block
    typedef struct packed {
        logic        frame_ok;
        logic        overflow;
        logic        cpu_valid;
        logic [7:0]  cpu_load;
        logic        ip_valid;
        logic [7:0]  ip_count;
        logic [3:0]  address_index;
        logic [31:0] ip_address;
        logic        last;
    } t_deframe_result;

    // Shapes of the tagged fields in generated frames
    typedef enum int {CPU_NONE, CPU_ONE, CPU_EMPTY, CPU_TWO} t_cpu_form;
    typedef enum int {IP_NONE, IP_EXACT, IP_SHORT, IP_LONG} t_ip_form;

    // Mirror of the frame store plus the queue of results still owed by the block
    class t_deframe_scoreboard;
        logic [7:0]      store [FRAME_DEPTH];
        int              fill;
        bit              spilled;
        t_deframe_result awaited [$];
        int errors;
        int bytes_seen;
        int frames_seen;
        int frames_good;
        int frames_spilled;
        int address_results;
        int results_predicted;
        int results_checked;

        function new();
            clear_store();
            errors = 0;
            bytes_seen = 0;
            frames_seen = 0;
            frames_good = 0;
            frames_spilled = 0;
            address_results = 0;
            results_predicted = 0;
            results_checked = 0;
        endfunction

        function void clear_store();
            foreach (store[i]) store[i] = 8'h00;
            fill = 0;
            spilled = 1'b0;
        endfunction

        function void owe(t_deframe_result r);
            awaited.push_back(r);
            results_predicted++;
        endfunction

        // Find the last field opened by '#' and the tag; it ends before the next '#' or '>'
        function bit find_field(int len, logic [7:0] tag, output int lo, output int hi);
            bit open_f;
            bit have_lo;
            bit have_hi;
            open_f = 1'b0;
            have_lo = 1'b0;
            have_hi = 1'b0;
            lo = 0;
            hi = 0;
            for (int i = 0; i < len; i++) begin
                if (store[i] == CH_TAG && i + 1 < len && store[i + 1] == tag) begin
                    lo = i + 2;
                    have_lo = 1'b1;
                    have_hi = 1'b0;
                    open_f = 1'b1;
                end else if (open_f && (store[i] == CH_TAG || store[i] == CH_CLOSE)) begin
                    hi = i - 1;
                    have_hi = 1'b1;
                    open_f = 1'b0;
                end
            end
            return have_lo && have_hi;
        endfunction

        // Take one accepted byte; on a closing byte work out the frame's results
        function void note_byte(logic [7:0] b);
            t_deframe_result r;
            int len;
            int c_lo;
            int c_hi;
            int i_lo;
            int i_hi;
            int cnt;
            int q;
            logic [31:0] addr;
            bytes_seen++;
            if (fill < FRAME_DEPTH) begin
                store[fill] = b;
                fill++;
            end else begin
                spilled = 1'b1;
            end
            if (b != CH_CLOSE) return;
            frames_seen++;
            r = '0;
            r.last = 1'b1;
            len = fill;
            // Drop an overflowed frame
            if (spilled) begin
                r.overflow = 1'b1;
                frames_spilled++;
                owe(r);
                clear_store();
                return;
            end
            // Reject bad start marker or length byte
            if (len < 2 || store[0] != CH_OPEN || int'(store[1]) != len) begin
                owe(r);
                clear_store();
                return;
            end
            frames_good++;
            r.frame_ok = 1'b1;
            if (find_field(len, CH_CPU, c_lo, c_hi) && c_hi == c_lo && c_lo < len) begin
                r.cpu_valid = 1'b1;
                r.cpu_load = store[c_lo];
            end
            cnt = 0;
            if (find_field(len, CH_IP, i_lo, i_hi) && i_hi >= i_lo && i_lo < len) begin
                cnt = store[i_lo];
                r.ip_count = store[i_lo];
                r.ip_valid = (i_hi - i_lo + 1 == cnt * 4 + 1) && cnt <= ADDR_LIMIT;
            end
            if (!r.ip_valid || cnt == 0) begin
                owe(r);
                clear_store();
                return;
            end
            // One result per address, last mark on the final one
            for (int k = 0; k < cnt; k++) begin
                addr = '0;
                for (int t = 0; t < 4; t++) begin
                    q = i_lo + 1 + 4 * k + t;
                    addr = {addr[23:0], (q < FRAME_DEPTH) ? store[q] : 8'h00};
                end
                r.address_index = 4'(k);
                r.ip_address = addr;
                r.last = (k == cnt - 1);
                address_results++;
                owe(r);
            end
            clear_store();
        endfunction

        function string show(t_deframe_result r);
            return $sformatf("ok=%0b ovf=%0b cpu=%0b/%02h ip=%0b cnt=%0d idx=%0d addr=%08h last=%0b",
                             r.frame_ok, r.overflow, r.cpu_valid, r.cpu_load, r.ip_valid,
                             r.ip_count, r.address_index, r.ip_address, r.last);
        endfunction

        // Compare one delivered result with the oldest one owed
        function void check_result(t_deframe_result got);
            t_deframe_result want;
            string wrong;
            results_checked++;
            if (awaited.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: result with none owed: %s", show(got));
                return;
            end
            want = awaited.pop_front();
            wrong = "";
            if (got.frame_ok !== want.frame_ok) wrong = {wrong, " frame_ok"};
            if (got.overflow !== want.overflow) wrong = {wrong, " overflow"};
            if (got.cpu_valid !== want.cpu_valid) wrong = {wrong, " cpu_valid"};
            if (got.cpu_load !== want.cpu_load) wrong = {wrong, " cpu_load"};
            if (got.ip_valid !== want.ip_valid) wrong = {wrong, " ip_valid"};
            if (got.ip_count !== want.ip_count) wrong = {wrong, " ip_count"};
            if (got.address_index !== want.address_index) wrong = {wrong, " address_index"};
            if (got.ip_address !== want.ip_address) wrong = {wrong, " ip_address"};
            if (got.last !== want.last) wrong = {wrong, " last"};
            if (wrong != "") begin
                errors++;
                if (errors <= 10) begin
                    $display("ERROR: result %0d wrong in%s", results_checked, wrong);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_frame_ok;
    logic        o_overflow;
    logic        o_cpu_valid;
    logic [7:0]  o_cpu_load;
    logic        o_ip_valid;
    logic [7:0]  o_ip_count;
    logic [3:0]  o_address_index;
    logic [31:0] o_ip_address;
    logic        o_last;

    t_deframe_scoreboard ledger = new();
    logic [7:0]          frame_q [$];
    int                  idle_pct = 35;

    status_frame_deframer_top #(
        .BUFFER_DEPTH  (FRAME_DEPTH),
        .MAX_ADDRESSES (ADDR_LIMIT)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_frame_ok      (o_frame_ok),
        .o_overflow      (o_overflow),
        .o_cpu_valid     (o_cpu_valid),
        .o_cpu_load      (o_cpu_load),
        .o_ip_valid      (o_ip_valid),
        .o_ip_count      (o_ip_count),
        .o_address_index (o_address_index),
        .o_ip_address    (o_ip_address),
        .o_last          (o_last)
    );

    always #4 i_clk = ~i_clk;

    // Stall the result channel at random
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // Check every result taken
    always @(posedge i_clk) begin : result_monitor
        t_deframe_result got;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            got.frame_ok = o_frame_ok;
            got.overflow = o_overflow;
            got.cpu_valid = o_cpu_valid;
            got.cpu_load = o_cpu_load;
            got.ip_valid = o_ip_valid;
            got.ip_count = o_ip_count;
            got.address_index = o_address_index;
            got.ip_address = o_ip_address;
            got.last = o_last;
            ledger.check_result(got);
        end
    end

    // Field content: never a closing byte, rarely a tag byte
    function automatic logic [7:0] data_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom);
        end while (b == CH_CLOSE || (b == CH_TAG && $urandom_range(0, 9) != 0));
        return b;
    endfunction

    // Filler outside fields: neither tag nor closing byte
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom);
        end while (b == CH_CLOSE || b == CH_TAG);
        return b;
    endfunction

    // Assemble a frame with a correct header and the requested fields
    function automatic void build_frame(t_cpu_form cf, t_ip_form ipf, int cnt, bit cpu_first);
        logic [7:0] cpu_part [$];
        logic [7:0] ip_part [$];
        int nbody;
        if (cf != CPU_NONE) begin
            cpu_part.push_back(CH_TAG);
            cpu_part.push_back(CH_CPU);
        end
        if (cf == CPU_ONE || cf == CPU_TWO) cpu_part.push_back(data_byte());
        if (cf == CPU_TWO) cpu_part.push_back(data_byte());
        if (ipf != IP_NONE) begin
            ip_part.push_back(CH_TAG);
            ip_part.push_back(CH_IP);
            ip_part.push_back(8'(cnt));
            nbody = 4 * cnt + ((ipf == IP_LONG) ? 1 : 0) - ((ipf == IP_SHORT) ? 1 : 0);
            for (int i = 0; i < nbody; i++) ip_part.push_back(data_byte());
        end
        frame_q.delete();
        frame_q.push_back(CH_OPEN);
        frame_q.push_back(8'h00);
        // Filler goes in front only: after a field it would lengthen the field
        repeat ($urandom_range(0, 3)) frame_q.push_back(noise_byte());
        if (cpu_first) begin
            foreach (cpu_part[i]) frame_q.push_back(cpu_part[i]);
            foreach (ip_part[i]) frame_q.push_back(ip_part[i]);
        end else begin
            foreach (ip_part[i]) frame_q.push_back(ip_part[i]);
            foreach (cpu_part[i]) frame_q.push_back(cpu_part[i]);
        end
        frame_q.push_back(CH_CLOSE);
        // A length of 62 would itself read as a closing byte
        if (frame_q.size() == 62) frame_q.insert(2, noise_byte());
        frame_q[1] = 8'(frame_q.size());
    endfunction

    function automatic void build_random_frame();
        int pick;
        int cnt;
        t_cpu_form cf;
        t_ip_form ipf;
        pick = $urandom_range(0, 9);
        cf = (pick < 3) ? CPU_NONE : (pick < 8) ? CPU_ONE : (pick < 9) ? CPU_EMPTY : CPU_TWO;
        pick = $urandom_range(0, 9);
        ipf = (pick < 2) ? IP_NONE : (pick < 8) ? IP_EXACT : (pick < 9) ? IP_SHORT : IP_LONG;
        cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 3);
        build_frame(cf, ipf, cnt, $urandom_range(0, 1));
    endfunction

    // Present one byte and hold it until the block takes it
    task automatic send_byte(logic [7:0] b);
        if ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < idle_pct);
        end
        i_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        ledger.note_byte(b);
    endtask

    task automatic send_frame();
        foreach (frame_q[i]) send_byte(frame_q[i]);
    endtask

    // Hold the sender until every owed result has been delivered
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (ledger.pending() > 0) @(posedge i_clk);
    endtask

    initial begin
        int pick;
        int nfill;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: header checks
        frame_q = '{CH_CLOSE};
        send_frame();
        frame_q = '{CH_OPEN, 8'd3, CH_CLOSE};
        send_frame();
        frame_q = '{8'h00, 8'd3, CH_CLOSE};
        send_frame();
        frame_q = '{CH_OPEN, 8'd4, CH_CLOSE};
        send_frame();
        // Directed: CPU field forms
        frame_q = '{CH_OPEN, 8'd6, CH_TAG, CH_CPU, 8'hFF, CH_CLOSE};
        send_frame();
        frame_q = '{CH_OPEN, 8'd9, CH_TAG, CH_CPU, 8'h00, CH_TAG, CH_CPU, 8'h80, CH_CLOSE};
        send_frame();
        frame_q = '{CH_OPEN, 8'd7, CH_TAG, CH_CPU, CH_TAG, 8'h41, CH_CLOSE};
        send_frame();
        frame_q = '{CH_OPEN, 8'd5, CH_TAG, CH_CPU, CH_CLOSE};
        send_frame();
        // Directed: IP field forms
        frame_q = '{CH_OPEN, 8'd14, CH_TAG, CH_IP, 8'd2, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    8'h00, 8'h00, 8'h00, 8'h00, CH_CLOSE};
        send_frame();
        frame_q = '{CH_OPEN, 8'd6, CH_TAG, CH_IP, 8'd0, CH_CLOSE};
        send_frame();
        frame_q = '{CH_OPEN, 8'd9, CH_TAG, CH_IP, 8'd1, 8'd1, 8'd2, 8'd3, CH_CLOSE};
        send_frame();
        frame_q = '{CH_OPEN, 8'd7, CH_TAG, CH_IP, 8'd17, 8'h05, CH_CLOSE};
        send_frame();
        build_frame(CPU_ONE, IP_EXACT, 13, 1'b0);
        send_frame();
        // Directed: frame filling the store exactly, then one byte too many
        for (int extra = 0; extra < 2; extra++) begin
            nfill = FRAME_DEPTH + extra;
            frame_q.delete();
            frame_q.push_back(CH_OPEN);
            frame_q.push_back(8'(nfill));
            while (frame_q.size() < nfill - 1) frame_q.push_back(noise_byte());
            frame_q.push_back(CH_CLOSE);
            send_frame();
        end
        drain();

        // Random frames, with a stretch of no idling on either side
        for (int f = 0; ledger.bytes_seen < 410 || ledger.results_predicted < 60; f++) begin
            idle_pct = (f >= 8 && f < 18) ? 0 : 35;
            pick = $urandom_range(0, 99);
            if (pick < 66) begin
                build_random_frame();
            end else if (pick < 80) begin
                // Corrupt start marker or length byte of a sound frame
                build_random_frame();
                if ($urandom_range(0, 1) == 0) begin
                    do frame_q[0] = 8'($urandom);
                    while (frame_q[0] == CH_OPEN || frame_q[0] == CH_CLOSE);
                end else begin
                    do frame_q[1] = frame_q[1] + 8'($urandom_range(1, 5));
                    while (frame_q[1] == CH_CLOSE);
                end
            end else if (pick < 95) begin
                // Raw noise of any byte values
                frame_q.delete();
                repeat ($urandom_range(0, 9)) frame_q.push_back(8'($urandom));
                frame_q.push_back(CH_CLOSE);
            end else begin
                // Overlong frame
                frame_q.delete();
                frame_q.push_back(CH_OPEN);
                repeat ($urandom_range(FRAME_DEPTH, FRAME_DEPTH + 20))
                    frame_q.push_back(noise_byte());
                frame_q.push_back(CH_CLOSE);
            end
            send_frame();
            if (f == 25) drain();
        end

        idle_pct = 35;
        drain();
        repeat (40) @(posedge i_clk);
        if (ledger.pending() > 0) begin
            ledger.errors++;
            $display("ERROR: %0d results never delivered", ledger.pending());
        end
        $display("Sent %0d bytes in %0d frames: %0d well formed, %0d overflowed.",
                 ledger.bytes_seen, ledger.frames_seen, ledger.frames_good,
                 ledger.frames_spilled);
        $display("Checked %0d results, %0d carrying addresses; %0d mismatches.",
                 ledger.results_checked, ledger.address_results, ledger.errors);
        if (ledger.errors == 0) begin
            $display("** status_frame_deframer_top: PASSED **");
        end else begin
            $display("** status_frame_deframer_top: FAILED **");
        end
        $finish;
    end

    // Give up on a hung run
    initial begin
        #2_000_000;
        $display("** status_frame_deframer_top: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
